[rtl/core/kcac_pkg.sv]
// Shared types and constants of the 3x3 convolution unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package kcac_pkg;

  localparam int MaxLine  = 1024;
  localparam int ColW     = $clog2(MaxLine);
  localparam int RowW     = 16;
  localparam int WidthW   = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KTOP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KMID   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KBOT   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd5;

  localparam logic [WidthW-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [RowW-1:0]     HEIGHT_RESET = 16'd768;
  localparam logic [CfgDataW-1:0] KTOP_RESET   = 48'h000001000000;
  localparam logic [CfgDataW-1:0] KMID_RESET   = 48'h0100FC000100;
  localparam logic [CfgDataW-1:0] KBOT_RESET   = 48'h000001000000;
  localparam logic [15:0]         SCALE_RESET  = 16'd4096;

  typedef logic [7:0] pix_t;

  // One interior position waiting for the arithmetic.
  typedef struct packed {
    pix_t [2:0][2:0]  win;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/kcac_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// Stand-alone; holds the line stores of the convolution unit.
module kcac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/kcac_front.sv]
// Front of the convolution unit: position tracking, line stores and window.
// Depends on kcac_pkg and kcac_ram; pushes interior positions as jobs.
module kcac_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      pixel,
  input  logic                            frame_start,
  input  logic [kcac_pkg::WidthW-1:0]     width_eff,
  input  logic [kcac_pkg::RowW-1:0]       height_eff,
  input  kcac_pkg::queue_status_t         qstat,
  output logic                            push,
  output kcac_pkg::job_t                  job
);

  localparam logic F_IDLE  = 1'b0;
  localparam logic F_WRITE = 1'b1;

  logic                        state;
  logic [kcac_pkg::RowW-1:0]   row_pos;
  logic [kcac_pkg::ColW-1:0]   col_pos;
  logic [kcac_pkg::RowW-1:0]   r_eff;
  logic [kcac_pkg::ColW-1:0]   c_eff;
  logic [kcac_pkg::ColW-1:0]   cur_col;
  logic [kcac_pkg::RowW-1:0]   cur_row;
  kcac_pkg::pix_t              cur_pix;
  logic                        emit;
  logic                        last;
  kcac_pkg::pix_t [2:0][2:0]   win;
  kcac_pkg::pix_t [2:0][2:0]   win_next;
  logic [15:0]                 rd_pair;
  logic                        accept;
  logic                        done;
  logic [kcac_pkg::WidthW-1:0] c_ext;
  logic [kcac_pkg::RowW:0]     r_inc;
  logic [kcac_pkg::ColW-1:0]   rd_addr;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && (state == F_IDLE);
  assign done     = (state == F_WRITE) && (!emit || !qstat.full);
  assign push     = done && emit;

  assign r_eff = frame_start ? '0 : row_pos;
  assign c_eff = frame_start ? '0 : col_pos;
  assign c_ext = {1'b0, c_eff};
  assign r_inc = {1'b0, r_eff} + 17'd1;

  // While a pixel waits for room in the queue its own column is read again,
  // so the line store pair stays put until the write-back.
  assign rd_addr = (state == F_IDLE) ? c_eff : cur_col;

  // Upper store half in bits 15..8, lower in 7..0; a column shifts up on write.
  kcac_ram #(.WIDTH(16), .DEPTH(kcac_pkg::MaxLine)) u_lines (
    .clk   (clk),
    .we    (done),
    .waddr (cur_col),
    .wdata ({rd_pair[7:0], cur_pix}),
    .raddr (rd_addr),
    .rdata (rd_pair)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = rd_pair[15:8];
    win_next[1][2] = rd_pair[7:0];
    win_next[2][2] = cur_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      row_pos <= '0;
      col_pos <= '0;
      win     <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_WRITE;
            if (c_ext + 11'd1 >= width_eff) begin
              col_pos <= '0;
              row_pos <= (r_inc >= {1'b0, height_eff}) ? '0 : r_inc[kcac_pkg::RowW-1:0];
            end else begin
              col_pos <= c_eff + 10'd1;
              row_pos <= r_eff;
            end
          end
        end
        F_WRITE: begin
          if (done) begin
            state <= F_IDLE;
            win   <= win_next;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pix <= pixel;
      cur_col <= c_eff;
      cur_row <= r_eff;
      emit    <= (r_eff >= 16'd2) && (c_eff >= 10'd2) && (r_eff < height_eff)
                 && (c_ext < width_eff);
      last    <= (r_eff == height_eff - 16'd1) && (c_ext == width_eff - 11'd1);
    end
  end

  always_comb begin
    job.win  = win_next;
    job.row  = cur_row - 16'd1;
    job.col  = cur_col - 10'd1;
    job.last = last;
  end

endmodule

[rtl/core/kcac_queue.sv]
// Two-entry queue of jobs between the front and the back.
// Depends on kcac_pkg.
module kcac_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  kcac_pkg::job_t          din,
  input  logic                    pop,
  output kcac_pkg::job_t          dout,
  output kcac_pkg::queue_status_t qstat
);

  kcac_pkg::job_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign dout        = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/kcac_back.sv]
// Back of the convolution unit: multiply-accumulate over the window,
// absolute value, scale, rounding and saturation. Depends on kcac_pkg.
module kcac_back (
  input  logic                          clk,
  input  logic                          rst,
  input  kcac_pkg::queue_status_t       qstat,
  input  kcac_pkg::job_t                head,
  output logic                          pop,
  input  logic [kcac_pkg::CfgDataW-1:0] kernel_top,
  input  logic [kcac_pkg::CfgDataW-1:0] kernel_middle,
  input  logic [kcac_pkg::CfgDataW-1:0] kernel_bottom,
  input  logic [15:0]                   result_scale,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_value,
  output logic [kcac_pkg::RowW-1:0]     out_row,
  output logic [kcac_pkg::ColW-1:0]     out_col,
  output logic                          frame_last
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MAC   = 3'd1;
  localparam logic [2:0] B_SCALE = 3'd2;
  localparam logic [2:0] B_ROUND = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]                   state;
  kcac_pkg::job_t               job;
  logic [1:0]                   ki;
  logic [1:0]                   kj;
  logic [kcac_pkg::CfgDataW-1:0] krow;
  logic signed [15:0]           coef;
  logic signed [24:0]           prod;
  logic signed [27:0]           acc;
  logic [26:0]                  mag;
  logic [42:0]                  scaled;
  logic [43:0]                  rounded;

  assign pop = (state == B_IDLE) && !qstat.empty;

  always_comb begin
    case (ki)
      2'd0:    krow = kernel_top;
      2'd1:    krow = kernel_middle;
      default: krow = kernel_bottom;
    endcase
    case (kj)
      2'd0:    coef = signed'(krow[15:0]);
      2'd1:    coef = signed'(krow[31:16]);
      default: coef = signed'(krow[47:32]);
    endcase
    prod    = signed'({1'b0, job.win[ki][kj]}) * coef;
    mag     = acc[27] ? 27'(-acc) : acc[26:0];
    rounded = {1'b0, scaled} + 44'(1 << 19);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            state <= B_MAC;
          end
        end
        B_MAC: begin
          if (ki == 2'd2 && kj == 2'd2) begin
            state <= B_SCALE;
          end
        end
        B_SCALE: state <= B_ROUND;
        B_ROUND: begin
          state     <= B_OUT;
          out_valid <= 1'b1;
        end
        B_OUT: begin
          if (!out_stall) begin
            state     <= B_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job <= head;
        ki  <= '0;
        kj  <= '0;
        acc <= '0;
      end
      B_MAC: begin
        acc <= acc + 28'(prod);
        if (kj == 2'd2) begin
          kj <= '0;
          ki <= ki + 2'd1;
        end else begin
          kj <= kj + 2'd1;
        end
      end
      B_SCALE: scaled <= {16'd0, mag} * {27'd0, result_scale};
      B_ROUND: begin
        out_value  <= (rounded[43:20] > 24'd255) ? 8'd255 : rounded[27:20];
        out_row    <= job.row;
        out_col    <= job.col;
        frame_last <= job.last;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/kernel_convolution_abs_clip_unit.sv]
// 3x3 convolution with absolute value, rounding and clipping.
// Top level: configuration registers, front, job queue and back.
//
// Pixels enter in raster order on the input channel (in_valid/in_stall,
// pixel, frame_start); a frame_start beat puts the position to row 0,
// column 0. Each interior position gives one beat on the output channel
// (out_valid/out_stall) with out_value, out_row, out_col and frame_last.
// Border positions give no beat.
// The front takes no new pixel before the last one is written back: the line
// store read is registered, then the shifted column is written back.
// The back works on one result at a time, and holds it while the receiver
// stalls. Its steps: taking the job, nine multiply-accumulate steps on one
// 9x16 multiplier, the scale multiply, rounding and the output register.
// A two-entry queue lets the front keep taking pixels while the back works
// or the receiver stalls; when it is full, in_stall stays high on pixels that
// produce a result. The output holds steady while out_stall is high.
// Reset (rst, synchronous) loads the default geometry 1024x768, the
// Laplacian kernel times 256 and scale 4096/2^20, and clears position,
// window and queue. Line store contents are undefined until written.
// Registers are written through write_enable/write_index/write_data.
module kernel_convolution_abs_clip_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [kcac_pkg::CfgIdxW-1:0]  write_index,
  input  logic [kcac_pkg::CfgDataW-1:0] write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    pixel,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_value,
  output logic [15:0]                   out_row,
  output logic [9:0]                    out_col,
  output logic                          frame_last
);

  logic [kcac_pkg::WidthW-1:0]   image_width;
  logic [kcac_pkg::RowW-1:0]     image_height;
  logic [kcac_pkg::CfgDataW-1:0] kernel_top;
  logic [kcac_pkg::CfgDataW-1:0] kernel_middle;
  logic [kcac_pkg::CfgDataW-1:0] kernel_bottom;
  logic [15:0]                   result_scale;
  logic [kcac_pkg::WidthW-1:0]   width_eff;
  logic [kcac_pkg::RowW-1:0]     height_eff;
  kcac_pkg::queue_status_t       qstat;
  kcac_pkg::job_t                push_job;
  kcac_pkg::job_t                head;
  logic                          push;
  logic                          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= kcac_pkg::WIDTH_RESET;
      image_height  <= kcac_pkg::HEIGHT_RESET;
      kernel_top    <= kcac_pkg::KTOP_RESET;
      kernel_middle <= kcac_pkg::KMID_RESET;
      kernel_bottom <= kcac_pkg::KBOT_RESET;
      result_scale  <= kcac_pkg::SCALE_RESET;
    end else if (write_enable) begin
      case (write_index)
        kcac_pkg::REG_WIDTH:  image_width   <= write_data[kcac_pkg::WidthW-1:0];
        kcac_pkg::REG_HEIGHT: image_height  <= write_data[kcac_pkg::RowW-1:0];
        kcac_pkg::REG_KTOP:   kernel_top    <= write_data;
        kcac_pkg::REG_KMID:   kernel_middle <= write_data;
        kcac_pkg::REG_KBOT:   kernel_bottom <= write_data;
        kcac_pkg::REG_SCALE:  result_scale  <= write_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < 11'd3) begin
      width_eff = 11'd3;
    end else if (image_width > 11'(kcac_pkg::MaxLine)) begin
      width_eff = 11'(kcac_pkg::MaxLine);
    end else begin
      width_eff = image_width;
    end
    height_eff = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  kcac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .qstat       (qstat),
    .push        (push),
    .job         (push_job)
  );

  kcac_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (head),
    .qstat (qstat)
  );

  kcac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .kernel_top    (kernel_top),
    .kernel_middle (kernel_middle),
    .kernel_bottom (kernel_bottom),
    .result_scale  (result_scale),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .frame_last    (frame_last)
  );

`ifndef SYNTHESIS
  // A result always belongs to an interior position.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row != 16'd0) && (out_col != 10'd0))
    else $error("result at a border position");

  // The last result of a frame sits in the last interior column.
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> ({1'b0, out_col} == width_eff - 11'd2))
    else $error("frame_last off the last interior column");

  // The queue is never pushed while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("job queue overflow");

  // The back takes a job only from a non-empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job queue underflow");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench of the 3x3 convolution unit with abs, round and clip.
// Depends on kcac_pkg and kernel_convolution_abs_clip_unit; predicts all but typed beats.
module testbench;

  localparam int CycleLimit = 1000000;

  typedef struct {
    logic [7:0]  value;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } conv_result_t;

  typedef struct {
    kcac_pkg::pix_t p;
    logic           fs;
    int             want;
  } dir_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          write_enable = 1'b0;
  logic [kcac_pkg::CfgIdxW-1:0]  write_index = kcac_pkg::REG_WIDTH;
  logic [kcac_pkg::CfgDataW-1:0] write_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    pixel = '0;
  logic                          frame_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_value;
  logic [15:0]                   out_row;
  logic [9:0]                    out_col;
  logic                          frame_last;

  kernel_convolution_abs_clip_unit u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the configuration and of the filter state.
  int             width_reg = 1024;
  int             height_reg = 768;
  logic [47:0]    kern [3] = '{kcac_pkg::KTOP_RESET, kcac_pkg::KMID_RESET,
                               kcac_pkg::KBOT_RESET};
  int             scale_reg = 4096;
  kcac_pkg::pix_t upper_line [kcac_pkg::MaxLine];
  kcac_pkg::pix_t lower_line [kcac_pkg::MaxLine];
  kcac_pkg::pix_t win [3][3];
  int             row_pos = 0;
  int             col_pos = 0;

  conv_result_t conv_expected [$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_left = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  initial begin
    foreach (win[i, j]) win[i][j] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
  end

  function automatic longint coef(input logic [47:0] k, input int j);
    logic signed [15:0] s;
    s = k[16*j +: 16];
    return longint'(s);
  endfunction

  // Advances the shadow state by one pixel; returns 1 when it yields a result.
  function automatic bit conv_step(input kcac_pkg::pix_t px, input logic fs,
                                   output conv_result_t res);
    int             w, h, r, c;
    kcac_pkg::pix_t up, lo;
    longint         sum, mag, val;
    bit             has;
    w = width_reg < 3 ? 3 : (width_reg > kcac_pkg::MaxLine ? kcac_pkg::MaxLine : width_reg);
    h = height_reg < 3 ? 3 : height_reg;
    has = 0;
    res = '{default: '0};
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c] = lo;
    lower_line[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = px;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          sum += longint'(win[i][j]) * coef(kern[i], j);
      mag = (sum < 0) ? -sum : sum;
      val = (mag * scale_reg + (64'd1 << 19)) >>> 20;
      res.value = (val > 255) ? 8'd255 : val[7:0];
      res.row = r - 1;
      res.col = c - 1;
      res.last = (r == h - 1 && c == w - 1);
      has = 1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
    return has;
  endfunction

  task automatic push_beat(input kcac_pkg::pix_t p, input logic fs, input int want);
    conv_result_t res;
    bit           has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = conv_step(p, fs, res);
    // Typed expectations belong to one-result 3x3 frames, so the position is fixed.
    if (want >= 0) begin
      res = '{value: want, row: 16'd1, col: 10'd1, last: 1'b1};
      has = 1;
    end
    if (has) conv_expected.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    // Border pixels still in the front give no beat, so allow the full latency.
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kcac_pkg::CfgIdxW-1:0] idx, input logic [47:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      kcac_pkg::REG_WIDTH:  width_reg = data[10:0];
      kcac_pkg::REG_HEIGHT: height_reg = data[15:0];
      kcac_pkg::REG_KTOP:   kern[0] = data;
      kcac_pkg::REG_KMID:   kern[1] = data;
      kcac_pkg::REG_KBOT:   kern[2] = data;
      kcac_pkg::REG_SCALE:  scale_reg = data[15:0];
      default: ;
    endcase
  endtask

  function automatic kcac_pkg::pix_t rand_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Mostly small coefficients so that the results do not all saturate.
  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] k;
    k = {$urandom, $urandom};
    if ($urandom_range(3) != 0)
      for (int j = 0; j < 3; j++) k[16*j +: 16] = 16'($urandom_range(1024) - 512);
    return k;
  endfunction

  task automatic run_phase(input int w, input int h, input logic [47:0] kt,
                           input logic [47:0] km, input logic [47:0] kb,
                           input int sc, input int n_items);
    int   we, he, pos, sent;
    logic fs_next;
    wait_idle();
    write_reg(kcac_pkg::REG_WIDTH, w);
    write_reg(kcac_pkg::REG_HEIGHT, h);
    write_reg(kcac_pkg::REG_KTOP, kt);
    write_reg(kcac_pkg::REG_KMID, km);
    write_reg(kcac_pkg::REG_KBOT, kb);
    write_reg(kcac_pkg::REG_SCALE, sc);
    we = (w & 16'h7FF) < 3 ? 3 :
         ((w & 16'h7FF) > kcac_pkg::MaxLine ? kcac_pkg::MaxLine : (w & 16'h7FF));
    he = (h & 16'hFFFF) < 3 ? 3 : (h & 16'hFFFF);
    pos = 0;
    sent = 0;
    fs_next = 1'b1;
    while (sent < n_items) begin
      push_beat(rand_pixel(), fs_next, -1);
      fs_next = 1'b0;
      sent++;
      pos++;
      if (pos == we * he) begin
        pos = 0;
      end else if ($urandom_range(199) == 0) begin
        fs_next = 1'b1;
        pos = 0;
      end
    end
  endtask

  dir_beat_t dir_tbl [27] = '{
    '{8'd255, 1'b1, -1}, '{8'd255, 1'b0, -1}, '{8'd255, 1'b0, -1},
    '{8'd255, 1'b0, -1}, '{8'd255, 1'b0, -1}, '{8'd255, 1'b0, -1},
    '{8'd255, 1'b0, -1}, '{8'd255, 1'b0, -1}, '{8'd255, 1'b0, 0},
    '{8'd0, 1'b0, -1}, '{8'd0, 1'b0, -1}, '{8'd0, 1'b0, -1},
    '{8'd0, 1'b0, -1}, '{8'd255, 1'b0, -1}, '{8'd0, 1'b0, -1},
    '{8'd0, 1'b0, -1}, '{8'd0, 1'b0, -1}, '{8'd0, 1'b0, 255},
    '{8'd7, 1'b1, -1}, '{8'd200, 1'b0, -1}, '{8'd1, 1'b0, -1},
    '{8'd128, 1'b0, -1}, '{8'd127, 1'b0, -1}, '{8'd64, 1'b0, -1},
    '{8'd33, 1'b0, -1}, '{8'd254, 1'b0, -1}, '{8'd90, 1'b0, -1}
  };

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    conv_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (conv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %0d row %0d col %0d last %0d",
                   out_value, out_row, out_col, frame_last);
      end else begin
        e = conv_expected.pop_front();
        if (out_value !== e.value || out_row !== e.row || out_col !== e.col ||
            frame_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     e.value, e.row, e.col, e.last,
                     out_value, out_row, out_col, frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int idle_modes [4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{29, 29}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset kernel and scale stay; only the geometry shrinks to one 3x3 frame.
    write_reg(kcac_pkg::REG_WIDTH, 3);
    write_reg(kcac_pkg::REG_HEIGHT, 3);
    foreach (dir_tbl[i]) push_beat(dir_tbl[i].p, dir_tbl[i].fs, dir_tbl[i].want);

    // Extremes: clamped geometry, most negative and largest coefficients, scale ends.
    run_phase(0, 0, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, 65535, 40);
    run_phase(2047, 3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 0, 400);
    run_phase(20, 3, {3{16'h7FFF}}, {3{16'h0001}}, 48'hFFFF_FFFF_FFFF, 65535, 200);
    run_phase(17, 65535, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
              $urandom_range(65535), 90);

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_modes[m][0];
      recv_stall_pct = idle_modes[m][1];
      for (int ph = 0; ph < 4; ph++) begin
        if (m == 0 && ph == 1) begin
          wait_idle();
          hold_left <= 300;
        end
        run_phase($urandom_range(12, 3), $urandom_range(8, 3), rand_kernel_row(),
                  rand_kernel_row(), rand_kernel_row(),
                  ($urandom_range(3) == 0) ? $urandom_range(65535)
                                           : $urandom_range(8192, 512), 50);
      end
    end

    in_valid <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
